@@ design/calendar_date_midpoint_defines.svh @@
// ----------------------------------------------------------------------------
// Calendar date midpoint: assertion macros
// Shared checking macros, clocked on clk_i and quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_MIDPOINT_DEFINES_SVH
`define CALENDAR_DATE_MIDPOINT_DEFINES_SVH

// Check that a condition holds at every clock edge.
`define CDM_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its trigger.
`define CDM_ASSERT_IMPL(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cons)) \
    else $error(msg);

// Check that a consequent holds in the cycle after its trigger.
`define CDM_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

@@ design/cdm_pkg.sv @@
// ----------------------------------------------------------------------------
// Calendar date midpoint package
// Request and response types, calendar tables and reciprocal constants.
// ----------------------------------------------------------------------------
`default_nettype none

package cdm_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } date_t;

  typedef struct packed {
    logic [DAY_W-1:0]   first_day;
    logic [MONTH_W-1:0] first_month;
    logic [YEAR_W-1:0]  first_year;
    logic [DAY_W-1:0]   second_day;
    logic [MONTH_W-1:0] second_month;
    logic [YEAR_W-1:0]  second_year;
  } req_t;

  typedef struct packed {
    logic [DAY_W-1:0]   mid_day;
    logic [MONTH_W-1:0] mid_month;
    logic [YEAR_W-1:0]  mid_year;
  } rsp_t;

  // ceil(x / 100) for x below 2^15 as (x + 99) * C100_RECIP >> C100_SHIFT
  localparam int unsigned C100_SHIFT = 21;
  localparam logic [14:0] C100_RECIP = 15'(((64'd1 << C100_SHIFT) + 64'd99) / 64'd100);

  // year estimate n * 400 / 146097, rounded up reciprocal
  localparam int unsigned YEAR_SHIFT = 32;
  localparam logic [63:0] YearRecipWide =
    ((64'd400 << YEAR_SHIFT) + 64'd146096) / 64'd146097;
  localparam logic [23:0] YEAR_RECIP = YearRecipWide[23:0];

  localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
  localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

  // Days of a common year before the first of month m.
  function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [8:0] d;
    unique case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

@@ design/calendar_date_midpoint.sv @@
// ----------------------------------------------------------------------------
// Calendar date midpoint
// Converts two Gregorian dates to day numbers and returns the date halfway.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload          | handshake
//  --------+-----+------------------+---------------------------
//  req     | in  | cdm_pkg::req_t   | req_valid_i / req_stall_o
//  rsp     | out | cdm_pkg::rsp_t   | rsp_valid_o / rsp_stall_i
//
//  One request per cycle while req_stall_o is low; a new request can be
//  taken before earlier responses have left. The pipeline has eight
//  register stages.
//  Reset clears only the stage valid bits; no flush pass is needed.
//  A stalled response holds its stage; upstream stages keep filling until
//  no bubble is left, and only then does req_stall_o rise.
//
`default_nettype none

`include "calendar_date_midpoint_defines.svh"

module calendar_date_midpoint #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_stall_o,
  input  cdm_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_stall_i,
  output cdm_pkg::rsp_t rsp_o
);

  localparam int unsigned NumStg = 8;
  localparam logic [16:0] MaxYearW = 17'(MAX_YEAR);

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------

  // Clamp a zero day, an out of range month and a year above MAX_YEAR, the same way for both inputs.
  function automatic cdm_pkg::date_t clamp_date(input logic [4:0] d, input logic [3:0] m,
                                                input logic [13:0] y);
    cdm_pkg::date_t r;
    r.day   = (d == 5'd0) ? 5'd1 : d;
    r.month = (m == 4'd0) ? 4'd1 : ((m > cdm_pkg::DECEMBER) ? cdm_pkg::DECEMBER : m);
    r.year  = ({3'b000, y} > MaxYearW) ? MaxYearW[13:0] : y;
    return r;
  endfunction

  // ceil(y / 100) through a reciprocal multiply
  function automatic logic [7:0] ceil100(input logic [14:0] y);
    logic [30:0] p;
    p = (31'(y) + 31'd99) * 31'(cdm_pkg::C100_RECIP);
    return p[cdm_pkg::C100_SHIFT+7:cdm_pkg::C100_SHIFT];
  endfunction

  // Days in years 0 .. y-1, given c = ceil(y / 100).
  function automatic logic [22:0] days_before_year(input logic [14:0] y,
                                                   input logic [7:0] c);
    return 23'(y) * 23'd365 + ((23'(y) + 23'd3) >> 2) - 23'(c) + ((23'(c) + 23'd3) >> 2);
  endfunction

  // Leap test, given c = ceil(y / 100); for a century year c is y / 100.
  function automatic logic is_leap(input logic [14:0] y, input logic [7:0] c);
    logic div100;
    div100 = ((16'(c) * 16'd100) == 16'(y));
    return (y[1:0] == 2'b00) && (!div100 || (c[1:0] == 2'b00));
  endfunction

  // Day number of a date, day 1 being 1 January of year 0.
  function automatic logic [22:0] day_number(input cdm_pkg::date_t dt, input logic [7:0] c);
    logic lp;
    lp = is_leap(15'(dt.year), c) && (dt.month > cdm_pkg::FEBRUARY);
    return 23'(dt.day) + 23'(cdm_pkg::days_before_month(dt.month)) + 23'(lp)
         + days_before_year(15'(dt.year), c);
  endfunction

  // --------------------------------------------------------------------------
  // Stage flow control: a stage loads when empty or when its successor loads
  // --------------------------------------------------------------------------
  logic [NumStg-1:0] vld_q;
  logic [NumStg:0]   rdy;
  logic [NumStg-1:0] load;

  always_comb begin
    rdy[NumStg] = !rsp_stall_i;
    for (int k = NumStg - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    load[0] = rdy[0] && req_valid_i;
    for (int k = 1; k < NumStg; k++) begin
      load[k] = rdy[k] && vld_q[k-1];
    end
  end

  assign req_stall_o = !rdy[0];
  assign rsp_valid_o = vld_q[NumStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= req_valid_i;
      end
      for (int k = 1; k < NumStg; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  cdm_pkg::date_t s1_a_q, s1_b_q;          // clamped request
  cdm_pkg::date_t s2_a_q, s2_b_q;
  logic [7:0]     s2_ca_q, s2_cb_q;        // ceil(year / 100)
  logic [22:0]    s3_na_q, s3_nb_q;        // day numbers
  logic [22:0]    s4_n_q;                  // zero-based midpoint day
  logic [22:0]    s5_n_q;
  logic [14:0]    s5_e_q;                  // lowest candidate year
  logic [22:0]    s6_n_q;
  logic [14:0]    s6_e_q;
  logic [7:0]     s6_c_q [3];              // ceil(/100) of the three candidates
  logic [13:0]    s7_year_q;
  logic [8:0]     s7_rem_q;                // one-based day of year
  logic           s7_leap_q;
  cdm_pkg::rsp_t  rsp_q;

  // midpoint, minus one so that 1 January of year 0 is zero
  logic [23:0] sum_d;
  logic [22:0] n_d;
  assign sum_d = 24'(s3_na_q) + 24'(s3_nb_q);
  assign n_d   = sum_d[23:1] - 23'd1;

  // year estimate, then step back one so the true year is e, e+1 or e+2
  logic [46:0] yprod_d;
  logic [14:0] yest_d, e_d;
  assign yprod_d = 47'(s4_n_q) * 47'(cdm_pkg::YEAR_RECIP);
  assign yest_d  = yprod_d[46:32];
  assign e_d     = (yest_d == 15'd0) ? 15'd0 : yest_d - 15'd1;

  // pick the latest candidate whose start lies at or below the day
  logic [14:0] cand_y [3];
  logic [22:0] cand_start [3];
  logic        cand_leap [3];
  logic [14:0] year_d;
  logic [22:0] start_d;
  logic        leap_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cand_y[k]     = s6_e_q + 15'(k);
      cand_start[k] = days_before_year(cand_y[k], s6_c_q[k]);
      cand_leap[k]  = is_leap(cand_y[k], s6_c_q[k]);
    end
    priority if (cand_start[2] <= s6_n_q) begin
      year_d = cand_y[2]; start_d = cand_start[2]; leap_d = cand_leap[2];
    end else if (cand_start[1] <= s6_n_q) begin
      year_d = cand_y[1]; start_d = cand_start[1]; leap_d = cand_leap[1];
    end else begin
      year_d = cand_y[0]; start_d = cand_start[0]; leap_d = cand_leap[0];
    end
  end

  logic [22:0] rem_full_d;
  assign rem_full_d = s6_n_q - start_d + 23'd1;

  // month: count month ends passed, then take off the days before it
  logic [3:0] month_d;
  logic [8:0] mstart_d;
  logic [8:0] mday_d;

  always_comb begin
    month_d = 4'd1;
    for (int k = 1; k < 12; k++) begin
      if (s7_rem_q > cdm_pkg::days_before_month(4'(k + 1))
                     + 9'((k >= 2) && s7_leap_q)) begin
        month_d = month_d + 4'd1;
      end
    end
    mstart_d = cdm_pkg::days_before_month(month_d)
             + 9'(s7_leap_q && (month_d > cdm_pkg::FEBRUARY));
    mday_d   = s7_rem_q - mstart_d;
  end

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      s1_a_q <= clamp_date(req_i.first_day, req_i.first_month, req_i.first_year);
      s1_b_q <= clamp_date(req_i.second_day, req_i.second_month, req_i.second_year);
    end
    if (load[1]) begin
      s2_a_q  <= s1_a_q;
      s2_b_q  <= s1_b_q;
      s2_ca_q <= ceil100(15'(s1_a_q.year));
      s2_cb_q <= ceil100(15'(s1_b_q.year));
    end
    if (load[2]) begin
      s3_na_q <= day_number(s2_a_q, s2_ca_q);
      s3_nb_q <= day_number(s2_b_q, s2_cb_q);
    end
    if (load[3]) begin
      s4_n_q <= n_d;
    end
    if (load[4]) begin
      s5_n_q <= s4_n_q;
      s5_e_q <= e_d;
    end
    if (load[5]) begin
      s6_n_q <= s5_n_q;
      s6_e_q <= s5_e_q;
      for (int k = 0; k < 3; k++) begin
        s6_c_q[k] <= ceil100(s5_e_q + 15'(k));
      end
    end
    if (load[6]) begin
      s7_year_q <= year_d[13:0];
      s7_rem_q  <= rem_full_d[8:0];
      s7_leap_q <= leap_d;
    end
    if (load[7]) begin
      rsp_q.mid_day   <= mday_d[4:0];
      rsp_q.mid_month <= month_d;
      rsp_q.mid_year  <= s7_year_q;
    end
  end

  assign rsp_o = rsp_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `CDM_ASSERT_IMPL(a_empty_no_stall, !vld_q[0], !req_stall_o,
                   "request stalled while the first stage is empty")
  `CDM_ASSERT_NEXT(a_hold_mid, vld_q[3] && !rdy[4], $stable(s4_n_q) && vld_q[3],
                   "blocked midpoint stage lost its item")
  `CDM_ASSERT_IMPL(a_year_floor, vld_q[5], days_before_year(s6_e_q, s6_c_q[0]) <= s6_n_q,
                   "year estimate lies above the midpoint day")
  `CDM_ASSERT_IMPL(a_rem_range, vld_q[6],
                   (s7_rem_q >= 9'd1) && (s7_rem_q <= 9'd365 + 9'(s7_leap_q)),
                   "day of year outside its year")

endmodule

`default_nettype wire
